@@ sv/bint_pkg.sv @@
// Package for the bitmap-indexed trie node: sizes, codes, types and popcount.
`default_nettype none
package bint_pkg;

  // Slot selection: low SLOT_BITS hash bits, SLOTS real slots (at most 64).
  localparam int unsigned SLOT_BITS = 6;
  localparam int unsigned SLOTS     = 64;

  // Fixed field widths.
  localparam int unsigned MAP_W   = 64;
  localparam int unsigned CHILD_W = 64;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CELLS   = 64;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                 ins;
    logic [RANK_W-1:0]    rank;
    logic [CHILD_W-1:0]   child;
  } cell_ctrl_t;

  // Population count as a six-level adder tree.
  function automatic logic [COUNT_W-1:0] popcnt64(input logic [MAP_W-1:0] v);
    logic [COUNT_W-1:0] s [MAP_W];
    for (int i = 0; i < MAP_W; i++) begin
      s[i] = COUNT_W'(v[i]);
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int j = 0; j < (MAP_W >> (lvl + 1)); j++) begin
        s[j] = s[2*j] + s[2*j+1];
      end
    end
    return s[0];
  endfunction

endpackage
`default_nettype wire

@@ sv/bitmap_indexed_node_table.sv @@
// Top level of the bitmap-indexed trie node: sequencer, bitmap and cell chain.
`default_nettype none
// One node of a hash array mapped trie. In the accept cycle the slot is
// decoded and its rank (popcount of the occupied slots below it) is
// registered; then, in the ST_EXEC state, the row of 64 child cells acts in
// parallel, every cell above the rank taking its neighbor's entry on an
// insert, and the rank cell is read on a lookup. The result goes to an
// output register, so a new item is taken while a result still waits; an
// item finishes only once the previous result has been taken, so a stalled
// output holds the block in its update cycle. A new item is not taken
// while the block is still in ST_EXEC with the last one.
module bitmap_indexed_node_table
  import bint_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [63:0]         hash_value_i,
  input  wire logic [63:0]         child_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     found_o,
  output logic [5:0]               slot_rank_o,
  output logic [63:0]              child_out_o,
  output logic                     slot_taken_error_o,
  output logic [6:0]               child_count_o
);

  state_e state_q, state_d;

  logic [MAP_W-1:0]   map_q;
  logic [COUNT_W-1:0] count_q;

  // item registers
  logic               ins_q;
  logic               range_q;
  logic               hit_q;
  logic [RANK_W-1:0]  rank_q;
  logic [RANK_W-1:0]  slot_q;
  logic [CHILD_W-1:0] child_q;

  // result registers
  logic               out_valid_q;
  logic               found_q;
  logic [RANK_W-1:0]  rank_out_q;
  logic [CHILD_W-1:0] child_out_q;
  logic               err_q;

  logic               in_acc;
  logic               go;
  logic               do_ins;
  logic               busy;

  logic [RANK_W-1:0]  slot_sel;
  logic               in_range;
  logic [MAP_W-1:0]   below_mask;
  logic [RANK_W-1:0]  rank_sel;

  cell_ctrl_t         cell_ctrl;
  logic [CHILD_W-1:0] cell_data [CELLS];
  logic [CHILD_W-1:0] cell_rd   [CELLS];
  logic [CHILD_W-1:0] rd_data;

  // Slot decode and rank from the accepted item
  assign slot_sel   = RANK_W'(hash_value_i[SLOT_BITS-1:0]);
  assign in_range   = ({1'b0, slot_sel} < COUNT_W'(SLOTS));
  assign below_mask = (MAP_W'(1) << slot_sel) - MAP_W'(1);
  assign rank_sel   = RANK_W'(popcnt64(map_q & below_mask));

  assign in_acc = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EXEC;
      ST_EXEC: if (go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = 1'b0;
    go   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        go   = 1'b0;
      end
      ST_EXEC: begin
        busy = 1'b1;
        go   = !(out_valid_q && out_stall_i);
      end
      default: begin
        busy = 1'b0;
        go   = 1'b0;
      end
    endcase
  end

  assign in_stall_o = busy;
  assign do_ins     = go && (ins_q == REQ_INSERT) && range_q && !hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item and its rank
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ins_q   <= req_type_i;
      range_q <= in_range;
      hit_q   <= in_range && map_q[slot_sel];
      rank_q  <= rank_sel;
      slot_q  <= slot_sel;
      child_q <= child_value_i;
    end
  end

  // Occupancy bitmap and child count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      count_q <= '0;
    end else if (do_ins) begin
      map_q[slot_q] <= 1'b1;
      count_q       <= count_q + COUNT_W'(1);
    end
  end

  // Cell chain
  assign cell_ctrl.ins   = do_ins;
  assign cell_ctrl.rank  = rank_q;
  assign cell_ctrl.child = child_q;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic [CHILD_W-1:0] prev;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = cell_data[g-1];
    end
    bint_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .idx_i  (RANK_W'(g)),
      .prev_i (prev),
      .data_o (cell_data[g]),
      .rd_o   (cell_rd[g])
    );
  end

  // Gather the read from the one cell at the rank
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CELLS; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (go) begin
      if (ins_q == REQ_LOOKUP) begin
        found_q     <= hit_q;
        rank_out_q  <= hit_q ? rank_q : '0;
        child_out_q <= hit_q ? rd_data : '0;
        err_q       <= 1'b0;
      end else begin
        found_q     <= range_q && !hit_q;
        rank_out_q  <= (range_q && !hit_q) ? rank_q : '0;
        child_out_q <= '0;
        err_q       <= hit_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign slot_rank_o        = rank_out_q;
  assign child_out_o        = child_out_q;
  assign slot_taken_error_o = err_q;
  assign child_count_o      = count_q;

endmodule
`default_nettype wire

@@ sv/bint_cell.sv @@
// One entry of the compacted child array; shifts up from its lower neighbor.
`default_nettype none
module bint_cell
  import bint_pkg::*;
(
  input  wire logic                clk_i,
  input  wire cell_ctrl_t          ctrl_i,
  input  wire logic [RANK_W-1:0]   idx_i,
  input  wire logic [CHILD_W-1:0]  prev_i,
  output logic      [CHILD_W-1:0]  data_o,
  output logic      [CHILD_W-1:0]  rd_o
);

  logic [CHILD_W-1:0] data_q;
  logic [CHILD_W-1:0] data_d;
  logic               at_rank;
  logic               above_rank;

  assign at_rank    = (idx_i == ctrl_i.rank);
  assign above_rank = (idx_i > ctrl_i.rank);

  // Insert: cells above the rank take the neighbor's entry, the rank cell the new child
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins && above_rank) begin
      data_d = prev_i;
    end else if (ctrl_i.ins && at_rank) begin
      data_d = ctrl_i.child;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // read contribution, zero unless this cell sits at the rank
  assign rd_o   = at_rank ? data_q : '0;

endmodule
`default_nettype wire
